@@ sv/gbts_pkg.sv @@
// shared types and codes of the gap buffer text store
package gbts_pkg;

	// item modes
	localparam logic [1:0] MODE_INSERT    = 2'd0;
	localparam logic [1:0] MODE_BACKSPACE = 2'd1;
	localparam logic [1:0] MODE_READ      = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_RANGE   = 2'd2;
	localparam logic [1:0] ST_NOTHING = 2'd3;

	// sequencer states, one-hot
	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_CHECK = 6'b000010,
		S_MOVE  = 6'b000100,
		S_EDIT  = 6'b001000,
		S_READ  = 6'b010000,
		S_FIN   = 6'b100000
	} gbts_state_t;

endpackage

@@ sv/gap_buffer_text_store.sv @@
// gap buffer text store: one byte store with an inclusive gap and its sequencer
//
// usage
//   input channel (in_valid/in_ready) carries one request beat: mode, cursor_position
//   and char_in; modes are insert a byte at the cursor, backspace before the cursor
//   and read the byte at a logical position
//   output channel (out_valid/out_ready) carries one result beat per request: status,
//   char_out, text_length and left_length (the gap start after the request)
//   one request is worked on at a time; in_ready is high only while the block is idle
//   steps after accept: check the request; a read then reads the store, an insert or
//   backspace moves the gap to the cursor, one byte per cycle through the one-read
//   one-write store, and then edits; a rejected request or unused mode goes straight
//   from the check to the result step
//   reset clears the gap pointers so the gap covers the whole store and the text
//   is empty; the store itself needs no clearing pass
//   when the receiver stalls the result sits in the output register and the block
//   holds its last step until that beat is taken
module gap_buffer_text_store
	import gbts_pkg::*;
#(
	parameter int CAPACITY = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] mode,
	input  logic [9:0] cursor_position,
	input  logic [7:0] char_in,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] status,
	output logic [7:0] char_out,
	output logic [9:0] text_length,
	output logic [9:0] left_length
);

	localparam int AW = $clog2(CAPACITY);
	localparam int LW = AW + 1;
	// compare width wide enough for both the 10-bit cursor and the length
	localparam int CW = (LW > 10) ? LW : 10;

	gbts_state_t state_q;

	// latched request
	logic [1:0] mode_q;
	logic [9:0] pos_q;
	logic [7:0] ch_q;

	// gap pointers, inclusive
	logic [AW-1:0] gf_q;
	logic [AW-1:0] gl_q;

	// byte store, one read and one write port, registered read
	logic [7:0] text_store_q [CAPACITY];
	logic [7:0] rd_data_q;
	logic [AW-1:0] rd_addr;

	// write pending from the previous gap move step
	logic          wr_pend_q;
	logic [AW-1:0] wr_addr_q;

	logic          we;
	logic [AW-1:0] waddr;
	logic [7:0]    wdata;

	// working result of the request in progress
	logic [1:0] res_status_q;
	logic [7:0] rd_byte_q;

	// result register
	logic       out_valid_q;
	logic [1:0] status_q;
	logic [7:0] char_q;
	logic [9:0] text_length_q;
	logic [9:0] left_length_q;

	logic [LW-1:0] len;
	logic [LW-1:0] gap_size;
	logic [CW-1:0] len_c;
	logic [CW-1:0] pos_c;
	logic [CW-1:0] gf_c;
	logic [LW-1:0] rd_phys;
	logic          pos_lt_gf;
	logic          pos_gt_gf;
	logic          out_free;

	// text length is capacity minus gap size
	assign gap_size = LW'(gl_q) - LW'(gf_q) + LW'(1);
	assign len      = LW'(CAPACITY) - gap_size;
	assign len_c    = CW'(len);
	assign pos_c    = CW'(pos_q);
	assign gf_c     = CW'(gf_q);

	assign pos_lt_gf = pos_c < gf_c;
	assign pos_gt_gf = pos_c > gf_c;

	// physical address of a read: left part maps straight, right part skips the gap
	assign rd_phys = pos_lt_gf ? LW'(pos_c) : (LW'(pos_c) + gap_size);

	assign out_free = !out_valid_q || out_ready;

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign char_out    = char_q;
	assign text_length = text_length_q;
	assign left_length = left_length_q;

	// read address: the byte to move during a gap step, else the byte to read
	always_comb begin
		rd_addr = rd_phys[AW-1:0];
		if (state_q == S_MOVE) begin
			if (pos_lt_gf) begin
				rd_addr = gf_q - AW'(1);
			end else begin
				rd_addr = gl_q + AW'(1);
			end
		end
	end

	// write port: moved byte first, then the inserted byte
	always_comb begin
		we    = 1'b0;
		waddr = wr_addr_q;
		wdata = rd_data_q;
		if (wr_pend_q) begin
			we = 1'b1;
		end else if (state_q == S_EDIT && mode_q == MODE_INSERT) begin
			we    = 1'b1;
			waddr = gf_q;
			wdata = ch_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			text_store_q[waddr] <= wdata;
		end
		rd_data_q <= text_store_q[rd_addr];
	end

	// request latch and result payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_q <= mode;
			pos_q  <= cursor_position;
			ch_q   <= char_in;
		end
		if (state_q == S_CHECK) begin
			rd_byte_q <= 8'd0;
		end
		if (state_q == S_READ) begin
			rd_byte_q <= rd_data_q;
		end
		// payload loads only once the previous beat has left
		if (state_q == S_FIN && out_free) begin
			char_q        <= rd_byte_q;
			text_length_q <= len_c[9:0];
			left_length_q <= gf_c[9:0];
		end
	end

	// sequencer and gap pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			gf_q         <= '0;
			gl_q         <= AW'(CAPACITY - 1);
			wr_pend_q    <= 1'b0;
			wr_addr_q    <= '0;
			out_valid_q  <= 1'b0;
			status_q     <= ST_OK;
			res_status_q <= ST_OK;
		end else begin
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					priority if (mode_q == MODE_INSERT) begin
						priority if (gf_q == gl_q) begin
							res_status_q <= ST_FULL;
							state_q      <= S_FIN;
						end else if (pos_c > len_c) begin
							res_status_q <= ST_RANGE;
							state_q      <= S_FIN;
						end else begin
							res_status_q <= ST_OK;
							state_q      <= S_MOVE;
						end
					end else if (mode_q == MODE_BACKSPACE) begin
						priority if (pos_c > len_c) begin
							res_status_q <= ST_RANGE;
							state_q      <= S_FIN;
						end else if (pos_q == 10'd0) begin
							res_status_q <= ST_NOTHING;
							state_q      <= S_FIN;
						end else begin
							res_status_q <= ST_OK;
							state_q      <= S_MOVE;
						end
					end else if (mode_q == MODE_READ) begin
						if (pos_c >= len_c) begin
							res_status_q <= ST_RANGE;
							state_q      <= S_FIN;
						end else begin
							// store read issued this cycle
							res_status_q <= ST_OK;
							state_q      <= S_READ;
						end
					end else begin
						// unused mode leaves everything as is
						res_status_q <= ST_OK;
						state_q      <= S_FIN;
					end
				end
				S_MOVE: begin
					// one byte across the gap per cycle, written back in the next cycle
					priority if (pos_lt_gf) begin
						wr_pend_q <= 1'b1;
						wr_addr_q <= gl_q;
						gf_q      <= gf_q - AW'(1);
						gl_q      <= gl_q - AW'(1);
					end else if (pos_gt_gf) begin
						wr_pend_q <= 1'b1;
						wr_addr_q <= gf_q;
						gf_q      <= gf_q + AW'(1);
						gl_q      <= gl_q + AW'(1);
					end else begin
						wr_pend_q <= 1'b0;
						state_q   <= S_EDIT;
					end
				end
				S_EDIT: begin
					if (mode_q == MODE_INSERT) begin
						gf_q <= gf_q + AW'(1);
					end else begin
						gf_q <= gf_q - AW'(1);
					end
					state_q <= S_FIN;
				end
				S_READ: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						status_q <= res_status_q;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// the gap always keeps at least one slot
	assert property (@(posedge clk) disable iff (!arst_n) gf_q <= gl_q)
		else $error("gap start passed gap end");

	// a moved byte is written back only while the gap is still moving
	assert property (@(posedge clk) disable iff (!arst_n) wr_pend_q |-> state_q == S_MOVE)
		else $error("pending move write outside gap move");

	// gap start changes only while moving or editing
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_MOVE && state_q != S_EDIT) |=> $stable(gf_q))
		else $error("gap start changed outside an edit");

	// a result beat is never overwritten before it is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(left_length_q)
			&& $stable(status_q) && $stable(char_q)))
		else $error("result dropped while stalled");

endmodule

@@ tb/tb_gap_buffer_text_store.sv @@
// testbench for the gap buffer text store: directed rows, then random edits checked by a predictor
`timescale 1ns / 1ps

module tb_gap_buffer_text_store
	import gbts_pkg::*;
();

	localparam int CAPACITY         = 1024;
	localparam int RANDOM_PER_PHASE = 76;
	// worst case per beat: a gap move across the whole store plus sequencing and a long stall,
	// for the directed fill (about 1050 beats) and the random part, taken four times over
	localparam int CYCLE_LIMIT      = 4 * (1050 + 4 * RANDOM_PER_PHASE) * (CAPACITY + 40);

	// one result beat as the block reports it
	typedef struct packed {
		logic [1:0] status;
		logic [7:0] char_out;
		logic [9:0] text_length;
		logic [9:0] left_length;
	} text_result_t;

	// one directed stimulus row, repeated reps times; typed rows carry their own result
	typedef struct {
		logic [1:0]   mode;
		logic [9:0]   pos;
		logic [7:0]   ch;
		int           reps;
		bit           typed;
		text_result_t result;
	} edit_row_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] mode;
	logic [9:0] cursor_position;
	logic [7:0] char_in;
	logic       out_valid;
	logic       out_ready;
	logic [1:0] status;
	logic [7:0] char_out;
	logic [9:0] text_length;
	logic [9:0] left_length;

	// shadow copy of the text store and its inclusive gap
	logic [7:0] shadow_text [CAPACITY];
	int         gap_lo;
	int         gap_hi;

	text_result_t pending_results [$];
	edit_row_t    edit_rows [$];
	int           errors;
	int           cycle_count;
	int           sender_idle_pct;
	int           receiver_stall_pct;

	gap_buffer_text_store #(
		.CAPACITY(CAPACITY)
	) i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mode           (mode),
		.cursor_position(cursor_position),
		.char_in        (char_in),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.char_out       (char_out),
		.text_length    (text_length),
		.left_length    (left_length)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// bytes of text currently held: capacity minus the gap size
	function automatic int held_bytes();
		return CAPACITY - (gap_hi - gap_lo + 1);
	endfunction

	// slide the gap to a cursor, one byte across it per step
	function automatic void shift_gap_to(int pos);
		while (pos < gap_lo && gap_lo > 0) begin
			gap_lo--;
			shadow_text[gap_hi] = shadow_text[gap_lo];
			gap_hi--;
		end
		while (pos > gap_lo && gap_hi + 1 < CAPACITY) begin
			gap_hi++;
			shadow_text[gap_lo] = shadow_text[gap_hi];
			gap_lo++;
		end
	endfunction

	// apply one request to the shadow store and return the result the block should give
	function automatic text_result_t edit_text(logic [1:0] m, logic [9:0] p, logic [7:0] c);
		text_result_t res;
		int           held;
		int           pos;
		held = held_bytes();
		pos  = int'(p);
		res  = '0;
		res.status = ST_OK;
		case (m)
			MODE_INSERT: begin
				if (gap_lo == gap_hi) res.status = ST_FULL;
				else if (pos > held) res.status = ST_RANGE;
				else begin
					shift_gap_to(pos);
					shadow_text[gap_lo] = c;
					gap_lo++;
				end
			end
			MODE_BACKSPACE: begin
				if (pos > held) res.status = ST_RANGE;
				else if (pos == 0) res.status = ST_NOTHING;
				else begin
					shift_gap_to(pos);
					gap_lo--;
				end
			end
			MODE_READ: begin
				if (pos >= held) res.status = ST_RANGE;
				else if (pos < gap_lo) res.char_out = shadow_text[pos];
				else res.char_out = shadow_text[pos + (gap_hi - gap_lo + 1)];
			end
			default: ;
		endcase
		res.text_length = 10'(held_bytes());
		res.left_length = 10'(gap_lo);
		return res;
	endfunction

	task automatic add_row(input logic [1:0] m, input logic [9:0] p, input logic [7:0] c,
			input int reps, input bit typed, input logic [1:0] st, input logic [7:0] rd,
			input logic [9:0] len, input logic [9:0] left);
		edit_row_t row;
		row.mode   = m;
		row.pos    = p;
		row.ch     = c;
		row.reps   = reps;
		row.typed  = typed;
		row.result = '{st, rd, len, left};
		edit_rows.push_back(row);
	endtask

	// drive one request beat from a falling edge, hold it until taken, then predict its result
	task automatic send_beat(input logic [1:0] m, input logic [9:0] p, input logic [7:0] c,
			input bit use_typed, input text_result_t typed_res, output text_result_t predicted);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid        <= 1'b1;
		mode            <= m;
		cursor_position <= p;
		char_in         <= c;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predicted = edit_text(m, p, c);
		pending_results.push_back(use_typed ? typed_res : predicted);
		@(negedge clk);
	endtask

	task automatic report_field(input string name, input int want, input int got);
		errors++;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
	endtask

	// receiver side: ready changes at the falling edge, stalling at the current phase's rate
	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
	end

	// result checker: every accepted result beat against the oldest prediction
	always @(posedge clk) begin
		text_result_t got;
		text_result_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{status, char_out, text_length, left_length};
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result beat with nothing expected, expected none, actual %h",
					$time, got);
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status)
					report_field("status", want.status, got.status);
				if (got.char_out !== want.char_out)
					report_field("char_out", want.char_out, got.char_out);
				if (got.text_length !== want.text_length)
					report_field("text_length", want.text_length, got.text_length);
				if (got.left_length !== want.left_length)
					report_field("left_length", want.left_length, got.left_length);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		text_result_t predicted;
		edit_row_t    row;
		logic [1:0]   m;
		logic [9:0]   pos;
		logic [7:0]   ch;
		int           caret;
		int           held;
		int           roll;
		int           pick;
		int           ins_pct;
		int           phase;

		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		arst_n             = 1'b0;
		in_valid           = 1'b0;
		mode               = MODE_INSERT;
		cursor_position    = '0;
		char_in            = '0;

		// after reset the text is empty and the gap covers the whole store
		foreach (shadow_text[i]) shadow_text[i] = '0;
		gap_lo = 0;
		gap_hi = CAPACITY - 1;

		// directed rows; typed results where they are plain to see
		// empty text: nothing to read, nothing to delete, cursors past the end
		add_row(MODE_READ,      10'd0,    8'h00, 1, 1, ST_RANGE,   8'h00, 10'd0,    10'd0);
		add_row(MODE_BACKSPACE, 10'd0,    8'h00, 1, 1, ST_NOTHING, 8'h00, 10'd0,    10'd0);
		add_row(MODE_BACKSPACE, 10'd1,    8'h00, 1, 1, ST_RANGE,   8'h00, 10'd0,    10'd0);
		add_row(MODE_INSERT,    10'd1,    8'hFF, 1, 1, ST_RANGE,   8'h00, 10'd0,    10'd0);
		// unused mode leaves everything alone
		add_row(2'd3,           10'h3FF,  8'hFF, 1, 1, ST_OK,      8'h00, 10'd0,    10'd0);
		// build "5A 00 FF" with a left gap move on the last insert
		add_row(MODE_INSERT,    10'd0,    8'h00, 1, 1, ST_OK,      8'h00, 10'd1,    10'd1);
		add_row(MODE_INSERT,    10'd1,    8'hFF, 1, 1, ST_OK,      8'h00, 10'd2,    10'd2);
		add_row(MODE_INSERT,    10'd0,    8'h5A, 1, 1, ST_OK,      8'h00, 10'd3,    10'd1);
		// reads on both sides of the gap and one past the end
		add_row(MODE_READ,      10'd0,    8'h00, 1, 1, ST_OK,      8'h5A, 10'd3,    10'd1);
		add_row(MODE_READ,      10'd2,    8'h00, 1, 1, ST_OK,      8'hFF, 10'd3,    10'd1);
		add_row(MODE_READ,      10'd3,    8'h00, 1, 1, ST_RANGE,   8'h00, 10'd3,    10'd1);
		// delete at the end, then at cursor zero with a nonempty left part
		add_row(MODE_BACKSPACE, 10'd3,    8'h00, 1, 1, ST_OK,      8'h00, 10'd2,    10'd2);
		add_row(MODE_BACKSPACE, 10'd0,    8'h00, 1, 1, ST_NOTHING, 8'h00, 10'd2,    10'd2);
		// empty the left part, then an edit must still move the gap from zero
		add_row(MODE_BACKSPACE, 10'd1,    8'h00, 1, 1, ST_OK,      8'h00, 10'd1,    10'd0);
		add_row(MODE_INSERT,    10'd1,    8'hA5, 1, 1, ST_OK,      8'h00, 10'd2,    10'd2);
		add_row(MODE_READ,      10'd1,    8'h00, 1, 1, ST_OK,      8'hA5, 10'd2,    10'd2);
		// fill to one spare slot by typing at the front
		add_row(MODE_INSERT,    10'd0,    8'h61, 1021, 0, ST_OK,   8'h00, 10'd0,    10'd0);
		// full store refuses inserts at the front and at the end
		add_row(MODE_INSERT,    10'd0,    8'h00, 1, 1, ST_FULL,    8'h00, 10'd1023, 10'd1);
		add_row(MODE_INSERT,    10'h3FF,  8'hFF, 1, 1, ST_FULL,    8'h00, 10'd1023, 10'd1);
		add_row(MODE_READ,      10'd1022, 8'h00, 1, 1, ST_OK,      8'hA5, 10'd1023, 10'd1);
		add_row(MODE_READ,      10'h3FF,  8'h00, 1, 1, ST_RANGE,   8'h00, 10'd1023, 10'd1);
		// longest gap move: backspace at the very end of a full text
		add_row(MODE_BACKSPACE, 10'h3FF,  8'h00, 1, 1, ST_OK,      8'h00, 10'd1022, 10'd1022);
		add_row(MODE_BACKSPACE, 10'h3FF,  8'h00, 1, 1, ST_RANGE,   8'h00, 10'd1022, 10'd1022);
		add_row(MODE_INSERT,    10'd1022, 8'hFF, 1, 1, ST_OK,      8'h00, 10'd1023, 10'd1023);
		add_row(MODE_READ,      10'd1022, 8'h00, 1, 1, ST_OK,      8'hFF, 10'd1023, 10'd1023);

		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part runs with no idling on either side
		foreach (edit_rows[i]) begin
			row = edit_rows[i];
			repeat (row.reps) send_beat(row.mode, row.pos, row.ch, row.typed, row.result,
				predicted);
		end

		// random editing session: a caret that mostly moves locally, typing and deleting
		// around it, with reads and some malformed beats mixed in
		caret = held_bytes();
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
				1: begin sender_idle_pct = 62; receiver_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  receiver_stall_pct = 62; end
				default: begin sender_idle_pct = 21; receiver_stall_pct = 21; end
			endcase
			repeat (RANDOM_PER_PHASE) begin
				held = held_bytes();
				if (caret > held) caret = held;
				roll = $urandom_range(0, 99);
				ch   = 8'($urandom_range(0, 255));
				if (roll < 6) begin
					// noise: any mode, any cursor
					m   = 2'($urandom_range(0, 3));
					pos = 10'($urandom_range(0, 1023));
				end else begin
					if (roll < 12) caret = $urandom_range(0, held);
					else if (roll < 30) begin
						caret = caret + int'($urandom_range(0, 16)) - 8;
						if (caret < 0) caret = 0;
						if (caret > held) caret = held;
					end
					// keep the text length wandering over its whole range
					ins_pct = (held > 960) ? 25 : ((held < 64) ? 70 : 45);
					pick    = $urandom_range(0, 99);
					if (pick < ins_pct) begin
						m   = MODE_INSERT;
						pos = 10'(caret);
					end else if (pick < ins_pct + 30) begin
						m   = MODE_BACKSPACE;
						pos = 10'(caret);
					end else begin
						m = MODE_READ;
						if (held == 0 || $urandom_range(0, 9) == 0) pos = 10'(held);
						else pos = 10'($urandom_range(0, held - 1));
					end
				end
				send_beat(m, pos, ch, 1'b0, '0, predicted);
				if (roll >= 6 && predicted.status == ST_OK) begin
					if (m == MODE_INSERT) caret++;
					else if (m == MODE_BACKSPACE) caret--;
				end
			end
		end

		// drain: let the receiver take everything, then watch for stray beats
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

endmodule
